### rtl/u6502_pkg.sv
package u6502_pkg;

   typedef enum logic [1:0] {
      MODE_EXEC  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_LOAD  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      OP_BAD, OP_LAX, OP_SAX, OP_DCM, OP_INS, OP_ARR, OP_ALR, OP_ANC,
      OP_SLO, OP_SRE, OP_RLA, OP_RRA
   } op_type;

   typedef enum logic [3:0] {
      AM_NONE, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY,
      AM_INDX, AM_INDY
   } am_type;

   localparam logic [7:0] FL_N = 8'h80;
   localparam logic [7:0] FL_V = 8'h40;
   localparam logic [7:0] FL_Z = 8'h02;
   localparam logic [7:0] FL_C = 8'h01;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  opcode;
      logic [15:0] operand;
      logic [7:0]  data_byte;
      logic [7:0]  load_a;
      logic [7:0]  load_x;
      logic [7:0]  load_y;
      logic [7:0]  load_status;
      logic [15:0] load_pc;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  index_x;
      logic [7:0]  index_y;
      logic [7:0]  status;
      logic [15:0] prog_counter;
      logic [7:0]  read_byte;
      logic        unsupported;
   } rsp_type;

   typedef struct packed {
      op_type op;
      am_type am;
   } dec_type;

   function automatic dec_type decode(input logic [7:0] opc);
      dec_type d;
      d.op = OP_BAD;
      d.am = AM_NONE;
      case (opc)
         8'hAF: d = '{OP_LAX, AM_ABS};
         8'hBF: d = '{OP_LAX, AM_ABSY};
         8'hA7: d = '{OP_LAX, AM_ZP};
         8'hB7: d = '{OP_LAX, AM_ZPY};
         8'hB3: d = '{OP_LAX, AM_INDY};
         8'h8F: d = '{OP_SAX, AM_ABS};
         8'h87: d = '{OP_SAX, AM_ZP};
         8'h97: d = '{OP_SAX, AM_ZPY};
         8'h83: d = '{OP_SAX, AM_INDX};
         8'hCF: d = '{OP_DCM, AM_ABS};
         8'hC7: d = '{OP_DCM, AM_ZP};
         8'hEF: d = '{OP_INS, AM_ABS};
         8'hE7: d = '{OP_INS, AM_ZP};
         8'h6B: d = '{OP_ARR, AM_IMM};
         8'h4B: d = '{OP_ALR, AM_IMM};
         8'h0B: d = '{OP_ANC, AM_IMM};
         8'h0F: d = '{OP_SLO, AM_ABS};
         8'h1F: d = '{OP_SLO, AM_ABSX};
         8'h1B: d = '{OP_SLO, AM_ABSY};
         8'h07: d = '{OP_SLO, AM_ZP};
         8'h17: d = '{OP_SLO, AM_ZPX};
         8'h03: d = '{OP_SLO, AM_INDX};
         8'h13: d = '{OP_SLO, AM_INDY};
         8'h4F: d = '{OP_SRE, AM_ABS};
         8'h47: d = '{OP_SRE, AM_ZP};
         8'h2F: d = '{OP_RLA, AM_ABS};
         8'h27: d = '{OP_RLA, AM_ZP};
         8'h6F: d = '{OP_RRA, AM_ABS};
         8'h67: d = '{OP_RRA, AM_ZP};
         default: d = '{OP_BAD, AM_NONE};
      endcase
      return d;
   endfunction

endpackage

### rtl/u6502_if.sv
interface u6502_req_if;
   import u6502_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface u6502_rsp_if;
   import u6502_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### rtl/u6502_mem.sv
module u6502_mem #(
   parameter int AW = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [0:(1<<AW)-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule

### rtl/u6502_alu.sv
module u6502_alu (
   input  u6502_pkg::op_type   op,
   input  logic [7:0]          a_in,
   input  logic [7:0]          x_in,
   input  logic [7:0]          p_in,
   input  logic [7:0]          m_in,
   output logic [7:0]          a_out,
   output logic [7:0]          x_out,
   output logic [7:0]          p_out,
   output logic [7:0]          m_out,
   output logic                m_wr
);
   import u6502_pkg::*;

   logic       cin;
   logic       add_cin;
   logic [7:0] t;
   logic [7:0] addv;
   logic [8:0] sum;
   logic [7:0] diff;
   logic       do_add;

   // shared binary adder for INS and RRA; RRA adds with the bit shifted out
   assign cin     = p_in[0];
   assign add_cin = (op == OP_RRA) ? m_in[0] : cin;
   assign sum     = {1'b0, a_in} + {1'b0, addv} + {8'd0, add_cin};
   assign diff    = a_in - m_out;

   always_comb begin
      a_out  = a_in;
      x_out  = x_in;
      p_out  = p_in;
      m_out  = m_in;
      m_wr   = 1'b0;
      addv   = 8'd0;
      do_add = 1'b0;
      t      = a_in & m_in;
      case (op)
         OP_LAX: begin
            a_out = m_in;
            x_out = m_in;
         end
         OP_SAX: begin
            m_out = a_in & x_in;
            m_wr  = 1'b1;
         end
         OP_DCM: begin
            m_out = m_in - 8'd1;
            m_wr  = 1'b1;
         end
         OP_INS: begin
            m_out  = m_in + 8'd1;
            m_wr   = 1'b1;
            addv   = ~m_out;
            do_add = 1'b1;
         end
         OP_ARR: begin
            p_out[0] = t[0];
            a_out    = {cin, t[7:1]};
            p_out[6] = a_out[6] ^ a_out[5];
         end
         OP_ALR: begin
            p_out[0] = t[0];
            a_out    = {1'b0, t[7:1]};
         end
         OP_ANC: begin
            p_out[0] = t[7];
            a_out    = t;
         end
         OP_SLO: begin
            p_out[0] = m_in[7];
            m_out    = {m_in[6:0], 1'b0};
            m_wr     = 1'b1;
            a_out    = a_in | m_out;
         end
         OP_SRE: begin
            p_out[0] = m_in[0];
            m_out    = {1'b0, m_in[7:1]};
            m_wr     = 1'b1;
            a_out    = a_in ^ m_out;
         end
         OP_RLA: begin
            p_out[0] = m_in[7];
            m_out    = {m_in[6:0], cin};
            m_wr     = 1'b1;
            a_out    = a_in & m_out;
         end
         OP_RRA: begin
            m_out  = {cin, m_in[7:1]};
            m_wr   = 1'b1;
            addv   = m_out;
            do_add = 1'b1;
         end
         default: ;
      endcase
      // RRA adds with the carry shifted out of memory
      if (op == OP_RRA) begin
         p_out[0] = m_in[0];
      end
      if (do_add) begin
         p_out[0] = sum[8];
         p_out[6] = (a_in[7] ^ sum[7]) & (addv[7] ^ sum[7]);
         a_out    = sum[7:0];
      end
      if (op == OP_DCM) begin
         p_out[0] = a_in >= m_out;
         p_out[7] = diff[7];
         p_out[1] = diff == 8'd0;
      end else if (op != OP_SAX && op != OP_BAD) begin
         p_out[7] = a_out[7];
         p_out[1] = a_out == 8'd0;
      end
   end
endmodule

### rtl/undocumented_6502_opcode_unit.sv
// Undocumented 6502 opcode unit.
// req channel: one beat per item (mode, opcode, operand, data_byte, load_*).
// rsp channel: one beat per item with A, X, Y, status, PC, read_byte and
// the unsupported flag.
// Mode 0 executes one opcode against the internal byte memory, mode 1 writes
// a byte, mode 2 reads one, mode 3 loads all registers.
// Write and load items go through the data and done steps; read, immediate,
// unknown and direct-address opcodes through the data and exec steps; the
// indirect modes read the low pointer, then the high pointer, form the address
// and read the data on the single read port before the exec step.
// One item is in flight at a time; the next req beat is taken in the cycle
// the rsp beat leaves.
// Reset clears A, X, Y, status, PC and the control state; memory contents
// stay undefined until written.
// A stalled rsp beat holds its data and blocks the next request.
module undocumented_6502_opcode_unit #(
   parameter int MEM_DEPTH = 65536
) (
   input  logic clock,
   input  logic reset,
   u6502_req_if.sink   req,
   u6502_rsp_if.source rsp
);
   import u6502_pkg::*;

   localparam int AW = $clog2(MEM_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DATA, ST_PTR_HI, ST_PTR_EA, ST_FETCH, ST_EXEC, ST_DONE
   } state_type;

   state_type   state_ff;
   req_type     item_ff;
   dec_type     dec_ff;
   logic [7:0]  a_ff, x_ff, y_ff, p_ff;
   logic [15:0] pc_ff;
   logic [15:0] ea_ff;
   logic [7:0]  ptr_lo_ff;
   logic [7:0]  rbyte_ff;
   logic        bad_ff;
   logic        rsp_valid_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;
   logic [15:0]   raddr16;

   logic [7:0] a_new, x_new, p_new, m_new;
   logic       m_wr;
   logic [7:0] zp_ptr;
   logic [15:0] ea_calc;
   logic [7:0] alu_mem;
   logic       is_exec;
   logic       is_ind;

   u6502_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   u6502_alu u_alu (
      .op    (dec_ff.op),
      .a_in  (a_ff),
      .x_in  (x_ff),
      .p_in  (p_ff),
      .m_in  (alu_mem),
      .a_out (a_new),
      .x_out (x_new),
      .p_out (p_new),
      .m_out (m_new),
      .m_wr  (m_wr)
   );

   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = '{a_ff, x_ff, y_ff, p_ff, pc_ff, rbyte_ff, bad_ff};

   assign is_exec = (item_ff.mode == MODE_EXEC);
   assign is_ind  = (dec_ff.am == AM_INDX) || (dec_ff.am == AM_INDY);

   // immediate opcodes take their operand in place of the memory byte
   assign alu_mem = (dec_ff.am == AM_IMM) ? item_ff.operand[7:0] : mem_rdata;

   // zero-page pointer base for the indirect modes
   assign zp_ptr = (dec_ff.am == AM_INDX) ? (item_ff.operand[7:0] + x_ff)
                                          : item_ff.operand[7:0];

   // direct effective address; other modes use the operand as is
   always_comb begin
      ea_calc = item_ff.operand;
      if (is_exec) begin
         case (dec_ff.am)
            AM_ZP:   ea_calc = {8'd0, item_ff.operand[7:0]};
            AM_ZPX:  ea_calc = {8'd0, item_ff.operand[7:0] + x_ff};
            AM_ZPY:  ea_calc = {8'd0, item_ff.operand[7:0] + y_ff};
            AM_ABSX: ea_calc = item_ff.operand + {8'd0, x_ff};
            AM_ABSY: ea_calc = item_ff.operand + {8'd0, y_ff};
            default: ea_calc = item_ff.operand;
         endcase
      end
   end

   // pick the read address for the current step
   always_comb begin
      case (state_ff)
         ST_DATA:   raddr16 = (is_exec && is_ind) ? {8'd0, zp_ptr} : ea_calc;
         ST_PTR_HI: raddr16 = {8'd0, zp_ptr + 8'd1};
         default:   raddr16 = ea_ff;
      endcase
      mem_raddr = raddr16[AW-1:0];
   end

   // write back from mode 1 or the modify step
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = m_new;
      mem_waddr = ea_ff[AW-1:0];
      if (state_ff == ST_EXEC && is_exec && dec_ff.op != OP_BAD && m_wr) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_DONE && item_ff.mode == MODE_WRITE) begin
         mem_we    = 1'b1;
         mem_wdata = item_ff.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         a_ff         <= 8'd0;
         x_ff         <= 8'd0;
         y_ff         <= 8'd0;
         p_ff         <= 8'd0;
         pc_ff        <= 16'd0;
         rbyte_ff     <= 8'd0;
         bad_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  item_ff  <= req.data;
                  dec_ff   <= decode(req.data.opcode);
                  ea_ff    <= req.data.operand;
                  state_ff <= ST_DATA;
               end
            end
            ST_DATA: begin
               // data or low pointer read issued this cycle
               ea_ff <= ea_calc;
               if (!is_exec) begin
                  state_ff <= (item_ff.mode == MODE_READ) ? ST_EXEC : ST_DONE;
               end else if (is_ind) begin
                  state_ff <= ST_PTR_HI;
               end else begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_PTR_HI: begin
               // hold the low pointer byte, high pointer read issued
               ptr_lo_ff <= mem_rdata;
               state_ff  <= ST_PTR_EA;
            end
            ST_PTR_EA: begin
               // form the indirect address from both pointer bytes
               ea_ff <= (dec_ff.am == AM_INDY)
                      ? ({mem_rdata, ptr_lo_ff} + {8'd0, y_ff})
                      : {mem_rdata, ptr_lo_ff};
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               // data read issued at the indirect address
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               // data byte valid on the read port: commit the result
               if (item_ff.mode == MODE_READ) begin
                  rbyte_ff <= mem_rdata;
                  bad_ff   <= 1'b0;
               end else begin
                  rbyte_ff <= 8'd0;
                  bad_ff   <= (dec_ff.op == OP_BAD);
                  if (dec_ff.op != OP_BAD) begin
                     a_ff  <= a_new;
                     x_ff  <= x_new;
                     p_ff  <= p_new;
                     pc_ff <= pc_ff + ((dec_ff.am == AM_ABS || dec_ff.am == AM_ABSX ||
                              dec_ff.am == AM_ABSY) ? 16'd3 : 16'd2);
                  end
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_DONE: begin
               // write and load items finish here
               rbyte_ff <= 8'd0;
               bad_ff   <= 1'b0;
               if (item_ff.mode == MODE_LOAD) begin
                  a_ff  <= item_ff.load_a;
                  x_ff  <= item_ff.load_x;
                  y_ff  <= item_ff.load_y;
                  p_ff  <= item_ff.load_status;
                  pc_ff <= item_ff.load_pc;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp.data))
      else $error("response changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("request accepted while busy");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_EXEC || state_ff == ST_DONE)
      else $error("memory write outside commit step");
`endif
endmodule
